### hw/rtl/wsc_pkg.sv
// wiper sweep controller package: request and mode codes, thresholds,
// config and status structs shared by every module of the block
`timescale 1ns / 1ps

package wsc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ANGLE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_JOY_X = 3'd1;
  localparam logic [2:0] REQ_JOY_Y = 3'd2;
  localparam logic [2:0] REQ_RAIN  = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  // wiper modes
  localparam logic [2:0] MODE_STOP = 3'd0;
  localparam logic [2:0] MODE_LOW  = 3'd1;
  localparam logic [2:0] MODE_MID  = 3'd2;
  localparam logic [2:0] MODE_HIGH = 3'd3;
  localparam logic [2:0] MODE_AUTO = 3'd4;

  // rain windows
  localparam logic [1:0] WIN_DRY   = 2'd0;
  localparam logic [1:0] WIN_LIGHT = 2'd1;
  localparam logic [1:0] WIN_MID   = 2'd2;
  localparam logic [1:0] WIN_HEAVY = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_MAX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_MAX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LIMIT = 3'd7;

  localparam logic [SAMPLE_W-1:0] JOY_HIGH = 12'd2500;
  localparam logic [SAMPLE_W-1:0] JOY_LOW  = 12'd1500;

  localparam logic [ANGLE_W-1:0] STEP_LOW   = 8'd4;
  localparam logic [ANGLE_W-1:0] STEP_MID   = 8'd7;
  localparam logic [ANGLE_W-1:0] STEP_HIGH  = 8'd9;
  localparam logic [ANGLE_W-1:0] ANGLE_SAT  = 8'd255;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dry_max;
    logic [SAMPLE_W-1:0] low_min;
    logic [SAMPLE_W-1:0] low_max;
    logic [SAMPLE_W-1:0] mid_min;
    logic [SAMPLE_W-1:0] mid_max;
    logic [SAMPLE_W-1:0] heavy_min;
    logic [SAMPLE_W-1:0] heavy_max;
    logic [ANGLE_W-1:0]  sweep_limit;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [2:0]         mode;
    logic [1:0]         level;
    logic               working;
    logic               down;
  } status_t;

endpackage

### hw/rtl/wsc_if.sv
// request and result channel interfaces of the wiper sweep controller
// depends on wsc_pkg for field widths
`timescale 1ns / 1ps

interface wsc_req_if;
  import wsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, req_type, sample, input ready);
  modport sink (input valid, req_type, sample, output ready);
endinterface

interface wsc_res_if;
  import wsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] servo_angle;
  logic [2:0]         wiper_mode;
  logic [1:0]         rain_level;
  logic               sweeping;
  logic               sweep_down;
  modport source (output valid, servo_angle, wiper_mode, rain_level, sweeping, sweep_down,
                  input ready);
  modport sink (input valid, servo_angle, wiper_mode, rain_level, sweeping, sweep_down,
                output ready);
endinterface

### hw/rtl/wsc_cfg.sv
// configuration register file: rain windows and sweep limit
// depends on wsc_pkg
`timescale 1ns / 1ps

module wsc_cfg
  import wsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dry_max     <= 12'd400;
      cfg.low_min     <= 12'd600;
      cfg.low_max     <= 12'd900;
      cfg.mid_min     <= 12'd1200;
      cfg.mid_max     <= 12'd1500;
      cfg.heavy_min   <= 12'd1800;
      cfg.heavy_max   <= 12'd2100;
      cfg.sweep_limit <= 8'd180;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRY_MAX:     cfg.dry_max     <= cfg_data;
        CFG_LOW_MIN:     cfg.low_min     <= cfg_data;
        CFG_LOW_MAX:     cfg.low_max     <= cfg_data;
        CFG_MID_MIN:     cfg.mid_min     <= cfg_data;
        CFG_MID_MAX:     cfg.mid_max     <= cfg_data;
        CFG_HEAVY_MIN:   cfg.heavy_min   <= cfg_data;
        CFG_HEAVY_MAX:   cfg.heavy_max   <= cfg_data;
        CFG_SWEEP_LIMIT: cfg.sweep_limit <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/wsc_core.sv
// controller state and single-pass next-state logic for one request
// depends on wsc_pkg
`timescale 1ns / 1ps

module wsc_core
  import wsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [2:0]          req_type,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output status_t             st_next
);

  status_t             st;
  logic [SAMPLE_W-1:0] last_x;
  logic [SAMPLE_W-1:0] last_y;
  logic                x_seen;
  logic                y_seen;

  logic [SAMPLE_W-1:0] last_x_next;
  logic [SAMPLE_W-1:0] last_y_next;
  logic                x_seen_next;
  logic                y_seen_next;

  always_comb begin
    logic [1:0]         sel;
    logic [ANGLE_W-1:0] base;
    logic [ANGLE_W-1:0] step;
    logic [ANGLE_W:0]   sum;
    logic [1:0]         win;
    logic               win_hit;

    st_next     = st;
    last_x_next = last_x;
    last_y_next = last_y;
    x_seen_next = x_seen;
    y_seen_next = y_seen;
    sel     = st.mode[1:0] + st.level;
    base    = (sel == 2'd0) ? '0 : st.angle;
    step    = '0;
    sum     = '0;
    win     = WIN_DRY;
    win_hit = 1'b0;

    case (req_type)
      REQ_TICK: begin
        st_next.angle = base;
        if (st.working) begin
          case (sel)
            2'd1:    step = STEP_LOW;
            2'd2:    step = STEP_MID;
            2'd3:    step = STEP_HIGH;
            default: step = '0;
          endcase
          if (st.down) begin
            st_next.angle = (base >= step) ? base - step : '0;
          end else begin
            sum = {1'b0, base} + {1'b0, step};
            st_next.angle = sum[ANGLE_W] ? ANGLE_SAT : sum[ANGLE_W-1:0];
          end
          if (st_next.angle >= cfg.sweep_limit) begin
            st_next.down = 1'b1;
          end else if (st_next.angle == '0) begin
            st_next.down = 1'b0;
          end
        end
      end
      REQ_JOY_X: begin
        if (st.mode != MODE_AUTO && !(x_seen && sample == last_x)) begin
          if (sample > JOY_HIGH) begin
            st_next.mode    = MODE_HIGH;
            st_next.working = 1'b1;
          end else if (sample < JOY_LOW) begin
            st_next.mode = MODE_AUTO;
          end
          last_x_next = sample;
          x_seen_next = 1'b1;
        end
      end
      REQ_JOY_Y: begin
        if (st.mode != MODE_AUTO && !(y_seen && sample == last_y)) begin
          if (sample > JOY_HIGH) begin
            st_next.mode    = MODE_MID;
            st_next.working = 1'b1;
          end else if (sample < JOY_LOW) begin
            st_next.mode    = MODE_LOW;
            st_next.working = 1'b1;
          end
          last_y_next = sample;
          y_seen_next = 1'b1;
        end
      end
      REQ_RAIN: begin
        if (st.mode == MODE_AUTO) begin
          if (sample <= cfg.dry_max) begin
            win_hit = 1'b1;
            win     = WIN_DRY;
          end else if (sample >= cfg.low_min && sample <= cfg.low_max) begin
            win_hit = 1'b1;
            win     = WIN_LIGHT;
          end else if (sample >= cfg.mid_min && sample <= cfg.mid_max) begin
            win_hit = 1'b1;
            win     = WIN_MID;
          end else if (sample >= cfg.heavy_min && sample <= cfg.heavy_max) begin
            win_hit = 1'b1;
            win     = WIN_HEAVY;
          end
          // level doubles as the last window, gaps hold the previous level
          if (win_hit && win != st.level) begin
            st_next.level   = win;
            st_next.working = (win != WIN_DRY);
          end
        end
      end
      REQ_STOP: begin
        st_next.mode    = MODE_STOP;
        st_next.working = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      x_seen <= 1'b0;
      y_seen <= 1'b0;
    end else if (fire) begin
      st     <= st_next;
      x_seen <= x_seen_next;
      y_seen <= y_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      last_x <= last_x_next;
      last_y <= last_y_next;
    end
  end

  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_STOP |-> !st.working)
    else $error("wiper working while in stop mode");

  a_level_only_rain: assert property (@(posedge clk) disable iff (rst)
    fire && req_type != REQ_RAIN |=> $stable(st.level))
    else $error("rain level changed on a non-rain request");

  a_auto_sticky: assert property (@(posedge clk) disable iff (rst)
    fire && st.mode == MODE_AUTO && req_type != REQ_STOP |=> st.mode == MODE_AUTO)
    else $error("auto mode left without stop request");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("state changed without a request");

endmodule

### hw/rtl/wiper_sweep_controller_unit.sv
// top level of the wiper sweep controller: request register, state core,
// result register; depends on wsc_pkg, wsc_if, wsc_cfg and wsc_core
// an accepted request waits in the request register, then its result is registered in the result register
// throughput: one request per cycle unless the result side stalls, set by the state update in wsc_core
// the request register can take a new request while the previous result waits
// reset: synchronous active-high rst clears channel valids, state and config defaults
`timescale 1ns / 1ps

module wiper_sweep_controller_unit
  import wsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  wsc_req_if.sink               req,
  wsc_res_if.source             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg;
  status_t             st_next;
  logic                s1_valid;
  logic [2:0]          s1_type;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                res_valid;
  status_t             res_data;
  logic                advance;

  // request moves into the core when the result register can take it
  assign advance   = s1_valid && (!res_valid || res.ready);
  assign req.ready = !s1_valid || advance;

  wsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .req_type (s1_type),
    .sample   (s1_sample),
    .cfg      (cfg),
    .st_next  (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_type   <= req.req_type;
      s1_sample <= req.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= st_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.servo_angle = res_data.angle;
  assign res.wiper_mode  = res_data.mode;
  assign res.rain_level  = res_data.level;
  assign res.sweeping    = res_data.working;
  assign res.sweep_down  = res_data.down;

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !res.ready |-> !req.ready)
    else $error("request taken while both stages are full and stalled");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed request produced no result");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> s1_valid)
    else $error("accepted request lost before the core");

endmodule

### dv/wiper_sweep_controller_unit_tb.sv
// testbench for wiper_sweep_controller_unit: directed and random event traffic,
// every result checked against an in-bench model of the wiper state
// depends on wsc_pkg, wsc_if and the rtl of the block
`timescale 1ns / 1ps

module wiper_sweep_controller_unit_tb;
  import wsc_pkg::*;

  localparam cfg_t CFG_RESET = '{12'd400, 12'd600, 12'd900, 12'd1200, 12'd1500,
                                 12'd1800, 12'd2100, 8'd180};

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wsc_req_if req_ch();
  wsc_res_if res_ch();

  wiper_sweep_controller_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // wiper state as the block should hold it
  cfg_t               m_cfg;
  logic [2:0]         m_mode;
  logic [1:0]         m_level;
  logic [1:0]         m_window;
  logic               m_working;
  logic               m_down;
  logic [ANGLE_W-1:0] m_angle;
  logic [15:0]        m_last_x;
  logic [15:0]        m_last_y;

  status_t expected_status_q[$];
  int      n_fail = 0;
  int      burst_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  // applies one request to the wiper state and returns the status it leaves
  function automatic status_t advance_wiper(input logic [2:0] kind,
                                            input logic [SAMPLE_W-1:0] smp);
    status_t    s;
    int         sel;
    int         stride;
    int         nxt;
    logic [1:0] win;
    bit         hit;
    case (kind)
      REQ_TICK: begin
        sel = (int'(m_mode) + int'(m_level)) % 4;
        if (sel == 0) m_angle = '0;
        if (m_working) begin
          case (sel)
            1: stride = int'(STEP_LOW);
            2: stride = int'(STEP_MID);
            3: stride = int'(STEP_HIGH);
            default: stride = 0;
          endcase
          if (m_down) begin
            nxt = (int'(m_angle) >= stride) ? int'(m_angle) - stride : 0;
          end else begin
            nxt = int'(m_angle) + stride;
            if (nxt > int'(ANGLE_SAT)) nxt = int'(ANGLE_SAT);
          end
          m_angle = nxt[ANGLE_W-1:0];
          if (m_angle >= m_cfg.sweep_limit) m_down = 1'b1;
          else if (m_angle == '0) m_down = 1'b0;
        end
      end
      REQ_JOY_X: begin
        if (m_mode != MODE_AUTO && {4'b0, smp} != m_last_x) begin
          if (smp > JOY_HIGH) begin
            m_mode = MODE_HIGH;
            m_working = 1'b1;
          end else if (smp < JOY_LOW) begin
            m_mode = MODE_AUTO;
          end
          m_last_x = {4'b0, smp};
        end
      end
      REQ_JOY_Y: begin
        if (m_mode != MODE_AUTO && {4'b0, smp} != m_last_y) begin
          if (smp > JOY_HIGH) begin
            m_mode = MODE_MID;
            m_working = 1'b1;
          end else if (smp < JOY_LOW) begin
            m_mode = MODE_LOW;
            m_working = 1'b1;
          end
          m_last_y = {4'b0, smp};
        end
      end
      REQ_RAIN: begin
        if (m_mode == MODE_AUTO) begin
          if (smp <= m_cfg.dry_max) begin
            if (m_window != WIN_DRY) begin
              m_window = WIN_DRY;
              m_level = WIN_DRY;
              m_working = 1'b0;
            end
          end else begin
            hit = 1'b1;
            win = WIN_DRY;
            if (smp >= m_cfg.low_min && smp <= m_cfg.low_max) win = WIN_LIGHT;
            else if (smp >= m_cfg.mid_min && smp <= m_cfg.mid_max) win = WIN_MID;
            else if (smp >= m_cfg.heavy_min && smp <= m_cfg.heavy_max) win = WIN_HEAVY;
            else hit = 1'b0;
            // samples between windows hold the previous level
            if (hit && m_window != win) begin
              m_window = win;
              m_level = win;
              m_working = 1'b1;
            end
          end
        end
      end
      REQ_STOP: begin
        m_mode = MODE_STOP;
        m_working = 1'b0;
      end
      default: ;
    endcase
    s.angle = m_angle;
    s.mode = m_mode;
    s.level = m_level;
    s.working = m_working;
    s.down = m_down;
    return s;
  endfunction

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      n_fail++;
    end
  endtask

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    status_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_status_q.size() == 0) begin
          $error("result with no request pending: angle %0d mode %0d",
                 res_ch.servo_angle, res_ch.wiper_mode);
          n_fail++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("servo_angle", want.angle, res_ch.servo_angle);
          check_field("wiper_mode", want.mode, res_ch.wiper_mode);
          check_field("rain_level", want.level, res_ch.rain_level);
          check_field("sweeping", want.working, res_ch.sweeping);
          check_field("sweep_down", want.down, res_ch.sweep_down);
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_status_q.push_back(advance_wiper(req_ch.req_type, req_ch.sample));
    end
  end

  // result side stalls on its own pattern, picked at random from four
  initial begin
    int stall_mode;
    int cyc;
    res_ch.ready = 1'b0;
    stall_mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (cyc % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 1) == 1);
        2: res_ch.ready <= (cyc % 7 < 4);
        default: res_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
      cyc++;
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.sample <= smp;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes every register while the block is idle
  task automatic program_config(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    wait_until_drained();
    for (int i = 0; i < 8; i++) begin
      idx = CFG_IDX_W'(i);
      case (idx)
        CFG_DRY_MAX:   data = c.dry_max;
        CFG_LOW_MIN:   data = c.low_min;
        CFG_LOW_MAX:   data = c.low_max;
        CFG_MID_MIN:   data = c.mid_min;
        CFG_MID_MAX:   data = c.mid_max;
        CFG_HEAVY_MIN: data = c.heavy_min;
        CFG_HEAVY_MAX: data = c.heavy_max;
        // upper bits of the sweep limit write are don't-care
        default:       data = {4'($urandom), c.sweep_limit};
      endcase
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    m_cfg = c;
  endtask

  function automatic cfg_t phase_settings(input int phase);
    cfg_t c;
    int   b[7];
    int   acc;
    c = CFG_RESET;
    case (phase)
      1: c = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0};
      2: c = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
               12'd4095, 8'd255};
      3, 5: begin
        acc = $urandom_range(0, 500);
        for (int i = 0; i < 7; i++) begin
          b[i] = acc;
          acc += $urandom_range(1, 600);
          if (acc > 4095) acc = 4095;
        end
        c = '{12'(b[0]), 12'(b[1]), 12'(b[2]), 12'(b[3]), 12'(b[4]), 12'(b[5]),
              12'(b[6]), 8'(phase == 5 ? 1 : $urandom_range(1, 180))};
      end
      4: c = '{12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
               12'($urandom), 12'($urandom), 12'($urandom), 8'($urandom)};
      default: ;
    endcase
    return c;
  endfunction

  // window edges and their neighbors, or anything
  function automatic logic [SAMPLE_W-1:0] rain_sample();
    logic [SAMPLE_W-1:0] b;
    case ($urandom_range(0, 8))
      0: b = m_cfg.dry_max;
      1: b = m_cfg.low_min;
      2: b = m_cfg.low_max;
      3: b = m_cfg.mid_min;
      4: b = m_cfg.mid_max;
      5: b = m_cfg.heavy_min;
      6: b = m_cfg.heavy_max;
      default: return SAMPLE_W'($urandom);
    endcase
    return b + SAMPLE_W'($urandom_range(0, 2)) - 12'd1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] joy_sample();
    case ($urandom_range(0, 7))
      0: return JOY_LOW - 12'd1;
      1: return JOY_LOW;
      2: return JOY_HIGH;
      3: return JOY_HIGH + 12'd1;
      4: return '0;
      5: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_joystick_modes();
    send_request(REQ_TICK, 12'd0);
    send_request(REQ_JOY_X, JOY_HIGH);
    send_request(REQ_JOY_X, JOY_HIGH);
    send_request(REQ_JOY_X, 12'd4095);
    send_request(REQ_TICK, 12'd4095);
    send_request(REQ_JOY_Y, 12'd0);
    send_request(REQ_JOY_Y, 12'd0);
    send_request(REQ_JOY_Y, 12'd4095);
    send_request(REQ_JOY_Y, JOY_LOW);
    send_request(REQ_TICK, 12'd0);
    send_request(REQ_JOY_X, JOY_LOW - 12'd1);
    // joystick is ignored once in auto
    send_request(REQ_JOY_X, 12'd4095);
  endtask

  task automatic test_auto_rain_levels();
    send_request(REQ_RAIN, 12'd0);
    send_request(REQ_RAIN, 12'd401);
    send_request(REQ_RAIN, 12'd600);
    send_request(REQ_TICK, 12'd0);
    send_request(REQ_RAIN, 12'd1200);
    send_request(REQ_RAIN, 12'd2100);
    send_request(REQ_RAIN, 12'd4095);
    send_request(REQ_TICK, 12'd0);
    send_request(REQ_RAIN, 12'd400);
  endtask

  task automatic test_stop_and_unknown();
    send_request(REQ_STOP, 12'd4095);
    send_request(3'd5, 12'd4095);
    send_request(3'd6, 12'd0);
    send_request(3'd7, 12'd2222);
  endtask

  // drives the sweep into saturation, then low and zero sweep limits
  task automatic test_sweep_limits();
    cfg_t c;
    c = CFG_RESET;
    c.sweep_limit = 8'd255;
    program_config(c);
    send_request(REQ_STOP, 12'd0);
    send_request(REQ_JOY_X, 12'd2000);
    send_request(REQ_JOY_X, 12'd4095);
    repeat (34) send_request(REQ_TICK, SAMPLE_W'($urandom));
    c.sweep_limit = 8'd1;
    program_config(c);
    repeat (8) send_request(REQ_TICK, SAMPLE_W'($urandom));
    c.sweep_limit = 8'd0;
    program_config(c);
    repeat (8) send_request(REQ_TICK, SAMPLE_W'($urandom));
  endtask

  task automatic test_random_traffic(input int per_phase);
    int r;
    int hold_at;
    for (int phase = 0; phase < 6; phase++) begin
      program_config(phase_settings(phase));
      hold_at = $urandom_range(1, per_phase - 1);
      for (int i = 0; i < per_phase; i++) begin
        if (i == hold_at) wait_until_drained();
        r = $urandom_range(0, 99);
        if (r < 38) send_request(REQ_TICK, SAMPLE_W'($urandom));
        else if (r < 60) send_request(REQ_RAIN, rain_sample());
        else if (r < 68) send_request(REQ_JOY_X, joy_sample());
        else if (r < 76) send_request(REQ_JOY_Y, joy_sample());
        else if (r < 80) send_request(REQ_STOP, SAMPLE_W'($urandom));
        else if (r < 83) send_request(3'($urandom_range(5, 7)), SAMPLE_W'($urandom));
        // most of the traffic should reach auto mode, where rain counts
        else if (m_mode != MODE_AUTO)
          send_request(REQ_JOY_X, SAMPLE_W'($urandom_range(0, 1499)));
        else send_request(REQ_TICK, SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.sample = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DRY_MAX;
    cfg_data = '0;
    m_cfg = CFG_RESET;
    m_mode = MODE_STOP;
    m_level = WIN_DRY;
    m_window = WIN_DRY;
    m_working = 1'b0;
    m_down = 1'b0;
    m_angle = '0;
    m_last_x = 16'hffff;
    m_last_y = 16'hffff;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_joystick_modes();
    test_auto_rain_levels();
    test_stop_and_unknown();
    test_sweep_limits();
    test_random_traffic(215);
    wait_until_drained();

    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
